// ===== hdl/lfia_pkg.sv =====
// Shared types and codes for the lowest free ID allocator.
package lfia_pkg;

    localparam int ID_W     = 10;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
    } req_t;

    typedef struct packed {
        logic                is_allocated;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     result_id;
    } result_t;

endpackage

// ===== hdl/lfia_tree_mem.sv =====
// Full-bit tree store: one sibling pair per word, one write and one registered read per cycle.
module lfia_tree_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [1:0]               wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [1:0]               rdata
);

    logic [1:0] mem [DEPTH];
    logic [1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/lfia_seq.sv =====
// Sequencer: clearing pass, descent to the lowest free leaf, upward repair, leaf check.
module lfia_seq #(
    parameter int NUM_IDS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  lfia_pkg::req_t             req,
    output logic                       req_ready,
    output logic                       res_valid,
    output lfia_pkg::result_t          res,
    input  logic                       res_take,
    output logic                       mem_we,
    output logic [$clog2(NUM_IDS)-1:0] mem_waddr,
    output logic [1:0]                 mem_wdata,
    output logic [$clog2(NUM_IDS)-1:0] mem_raddr,
    input  logic [1:0]                 mem_rdata
);

    localparam int IW = $clog2(NUM_IDS);
    localparam int NW = IW + 1;               // node number, root is 1
    localparam int XW = IW + lfia_pkg::ID_W;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_ROOT  = 7'b0000100,
        S_DOWN  = 7'b0001000,
        S_UP    = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [IW-1:0]            clr_reg, clr_next;
    logic [NW-1:0]            node_reg, node_next;
    logic                     val_reg, val_next;     // value to place at node
    logic                     rel_reg, rel_next;     // release, leaf not yet checked
    lfia_pkg::result_t        res_reg, res_next;

    logic [XW-1:0]            id_w;
    logic [IW-1:0]            id_idx;
    logic                     id_in_range;
    logic [NW-1:0]            id_leaf;
    logic [NW-1:0]            child;
    logic                     old_bit;
    logic [1:0]               new_pair;
    logic [XW-1:0]            leaf_w;

    assign id_w        = XW'(req.id);
    assign id_idx      = id_w[IW-1:0];
    assign id_in_range = (id_w >> IW) == '0;
    assign id_leaf     = {1'b1, id_idx};
    assign child       = {node_reg[IW-1:0], mem_rdata[0]};
    assign old_bit     = mem_rdata[node_reg[0]];
    assign leaf_w      = XW'(child[IW-1:0]);

    always_comb
    begin
        new_pair              = mem_rdata;
        new_pair[node_reg[0]] = val_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        node_next  = node_reg;
        val_next   = val_reg;
        rel_next   = rel_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = clr_reg;
        mem_wdata  = 2'b00;
        mem_raddr  = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_next  = '0;
                    node_next = id_leaf;
                    val_next  = 1'b0;
                    rel_next  = 1'b0;
                    mem_raddr = IW'(id_leaf >> 1);
                    case (req.op)
                        lfia_pkg::OP_ALLOC:
                        begin
                            mem_raddr  = '0;
                            state_next = S_ROOT;
                        end
                        lfia_pkg::OP_RELEASE:
                        begin
                            rel_next = 1'b1;
                            if (id_in_range)
                            begin
                                state_next = S_UP;
                            end
                            else
                            begin
                                res_next.status = lfia_pkg::STATUS_NOT_ALLOC;
                                state_next      = S_DONE;
                            end
                        end
                        lfia_pkg::OP_CHECK:
                        begin
                            state_next = id_in_range ? S_CHECK : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ROOT:
            begin
                // root lives in bit 1 of word 0
                if (mem_rdata[1])
                begin
                    res_next.status = lfia_pkg::STATUS_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    node_next  = NW'(1);
                    mem_raddr  = IW'(1);
                    state_next = S_DOWN;
                end
            end
            S_DOWN:
            begin
                node_next = child;
                if (child[IW])
                begin
                    val_next           = 1'b1;
                    res_next.result_id = leaf_w[lfia_pkg::ID_W-1:0];
                    mem_raddr          = IW'(child >> 1);
                    state_next         = S_UP;
                end
                else
                begin
                    mem_raddr = child[IW-1:0];
                end
            end
            S_UP:
            begin
                rel_next = 1'b0;
                if (rel_reg && !old_bit)
                begin
                    res_next.status = lfia_pkg::STATUS_NOT_ALLOC;
                    state_next      = S_DONE;
                end
                else if (old_bit == val_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = IW'(node_reg >> 1);
                    mem_wdata = new_pair;
                    val_next  = &new_pair;
                    node_next = node_reg >> 1;
                    mem_raddr = IW'(node_reg >> 2);
                    if (node_reg == NW'(1))
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CHECK:
            begin
                res_next.is_allocated = old_bit;
                state_next            = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            rel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rel_reg   <= rel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        val_reg  <= val_next;
        res_reg  <= res_next;
    end

    assign req_ready = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res       = res_reg;

endmodule

// ===== hdl/lowest_free_id_allocator.sv =====
// Top level of the lowest free ID allocator: stream ports, sequencer, tree store, output register.
// Operation: allocate descends from the root to the lowest free leaf, then repairs upward;
// release repairs upward from its leaf; check reads the leaf; one tree level per cycle, one RAM port.
// Throughput: one transaction at a time; the next is taken once the result has left the
// sequencer, while the output register may still hold it.
// Reset: asynchronous, active low; a clearing pass then writes every word of the tree store to zero,
// with s_axis_tready low until it is done.
module lowest_free_id_allocator #(
    parameter int NUM_IDS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] id, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [9:0] result_id, [11:10] status, [12] is_allocated
);

    localparam int IW = $clog2(NUM_IDS);

    lfia_pkg::req_t    req;
    lfia_pkg::result_t seq_res;
    lfia_pkg::result_t out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic              seq_res_valid;
    logic              res_take;
    logic              out_free;

    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [1:0]        mem_wdata;
    logic [IW-1:0]     mem_raddr;
    logic [1:0]        mem_rdata;

    assign req.op = s_axis_tuser;
    assign req.id = s_axis_tdata[lfia_pkg::ID_W-1:0];

    // Tree walk: word p of the store holds full bits of nodes 2p and 2p+1,
    // so the root sits in bit 1 of word 0 and a step reads both children at once.
    lfia_seq #(
        .NUM_IDS (NUM_IDS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req       (req),
        .req_ready (s_axis_tready),
        .res_valid (seq_res_valid),
        .res       (seq_res),
        .res_take  (res_take),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    lfia_tree_mem #(
        .DEPTH (NUM_IDS)
    ) u_tree_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: frees the sequencer as soon as the result is parked here.
    assign out_free = !out_valid_reg || m_axis_tready;
    assign res_take = seq_res_valid && out_free;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = seq_res_valid;
            out_next       = seq_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.is_allocated, out_reg.status, out_reg.result_id};

endmodule

// ===== tb/lfia_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the ID allocator: predicts each reply from the accepted requests and compares.
module lfia_result_checker #(
    parameter int NUM_IDS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] id, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [9:0] result_id, [11:10] status, [12] is_allocated
    output int          mismatch_count,
    output int          pending
);

    // Full-bit tree: node 1 is the root, leaves NUM_IDS.. stand for the IDs.
    bit                occupied [2*NUM_IDS];
    lfia_pkg::result_t awaited  [$];

    // Walk up from a changed node, stopping once a parent already agrees.
    function automatic void refresh_parents(input int unsigned node);
        int unsigned parent;
        bit          both;
        while (node > 1)
        begin
            parent = node >> 1;
            both   = occupied[2*parent] & occupied[2*parent+1];
            if (occupied[parent] == both)
                break;
            occupied[parent] = both;
            node = parent;
        end
    endfunction

    function automatic lfia_pkg::result_t predict_outcome(
        input logic [lfia_pkg::OP_W-1:0] op,
        input logic [lfia_pkg::ID_W-1:0] id);
        lfia_pkg::result_t r;
        int unsigned       node;
        int unsigned       leaf;
        r    = '0;
        leaf = NUM_IDS + id;
        case (op)
            lfia_pkg::OP_ALLOC:
            begin
                if (occupied[1])
                    r.status = lfia_pkg::STATUS_FULL;
                else
                begin
                    // left child whenever it still has room: lowest free ID
                    node = 1;
                    while (node < NUM_IDS)
                        node = occupied[2*node] ? 2*node + 1 : 2*node;
                    occupied[node] = 1'b1;
                    refresh_parents(node);
                    r.result_id = lfia_pkg::ID_W'(node - NUM_IDS);
                end
            end
            lfia_pkg::OP_RELEASE:
            begin
                if (id >= NUM_IDS || !occupied[leaf])
                    r.status = lfia_pkg::STATUS_NOT_ALLOC;
                else
                begin
                    occupied[leaf] = 1'b0;
                    refresh_parents(leaf);
                end
            end
            lfia_pkg::OP_CHECK:
                r.is_allocated = (id < NUM_IDS) && occupied[leaf];
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic void flag_field(input string name, input int want, input int got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        lfia_pkg::result_t seen;
        lfia_pkg::result_t want;
        if (!rst_n)
        begin
            foreach (occupied[i])
                occupied[i] = 1'b0;
            awaited.delete();
            mismatch_count = 0;
        end
        else
        begin
            // reply first: a new request in the same cycle is always a later one
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = lfia_pkg::result_t'(m_axis_tdata[$bits(lfia_pkg::result_t)-1:0]);
                if (awaited.size() == 0)
                begin
                    $error("reply with no request outstanding: tdata=%h", m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited.pop_front();
                    flag_field("result_id", want.result_id, seen.result_id);
                    flag_field("status", want.status, seen.status);
                    flag_field("is_allocated", want.is_allocated, seen.is_allocated);
                    flag_field("tdata padding", 0,
                               m_axis_tdata[15:$bits(lfia_pkg::result_t)]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited.push_back(predict_outcome(s_axis_tuser,
                                                  s_axis_tdata[lfia_pkg::ID_W-1:0]));
        end
        pending = awaited.size();
    end

endmodule

// ===== tb/lowest_free_id_allocator_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the ID allocator: request stimulus, idling phases, watchdog and verdict.
module lowest_free_id_allocator_test;

    localparam int NUM_IDS       = 1024;
    localparam int CYCLE_LIMIT   = 400000;  // watchdog limit for the whole run
    localparam int SETTLE_CYCLES = 40;      // quiet time after the last reply, before the verdict

    // op code 3 has no meaning in the block; it must answer with all fields zero
    localparam logic [lfia_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [9:0] id, rest zero
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [9:0] result_id, [11:10] status, [12] is_allocated

    int mismatch_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    // Stimulus-side view of which IDs are held, used to aim releases and checks
    // at live IDs, to steer the pool level and to know when the pool is exhausted.
    bit granted [NUM_IDS];
    int granted_total = 0;

    int alloc_sent   = 0;
    int full_hits    = 0;
    int release_sent = 0;
    int check_sent   = 0;
    int unused_sent  = 0;

    lowest_free_id_allocator #(
        .NUM_IDS(NUM_IDS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    lfia_result_checker #(
        .NUM_IDS(NUM_IDS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatch_count(mismatch_count),
        .pending       (pending)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver back-pressure, redrawn every falling edge.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it. The stimulus
    // view of the pool is updated here, in issue order, which is also the
    // order the block serves transactions in.
    task automatic issue(input logic [lfia_pkg::OP_W-1:0] op,
                         input logic [lfia_pkg::ID_W-1:0] id);
        int unsigned slot;
        case (op)
            lfia_pkg::OP_ALLOC:
            begin
                alloc_sent++;
                if (granted_total < NUM_IDS)
                begin
                    slot = 0;
                    while (granted[slot])
                        slot++;
                    granted[slot] = 1'b1;
                    granted_total++;
                end
                else
                    full_hits++;
            end
            lfia_pkg::OP_RELEASE:
            begin
                release_sent++;
                if (id < NUM_IDS && granted[id])
                begin
                    granted[id] = 1'b0;
                    granted_total--;
                end
            end
            lfia_pkg::OP_CHECK:
                check_sent++;
            default:
                unused_sent++;
        endcase
        // random sender gaps; valid drops only when a gap is actually taken
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= 16'(id);
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Some held ID at a random spot, or any ID when nothing is held.
    function automatic logic [lfia_pkg::ID_W-1:0] pick_held_id();
        int unsigned slot;
        slot = $urandom_range(NUM_IDS-1);
        if (granted_total == 0)
            return lfia_pkg::ID_W'(slot);
        while (!granted[slot])
            slot = (slot + 1) % NUM_IDS;
        return lfia_pkg::ID_W'(slot);
    endfunction

    // One random transaction; the mix leans towards allocate below the target
    // occupancy and towards release above it, so the pool level can be steered.
    task automatic random_request(input int target);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 4)
            issue(OP_UNUSED, lfia_pkg::ID_W'($urandom));
        else if (roll < 16)
            issue(lfia_pkg::OP_CHECK,
                  $urandom_range(1) ? pick_held_id() : lfia_pkg::ID_W'($urandom));
        else if (roll < (granted_total < target ? 75 : 40))
            issue(lfia_pkg::OP_ALLOC, lfia_pkg::ID_W'($urandom));
        else
            issue(lfia_pkg::OP_RELEASE,
                  ($urandom_range(4) != 0) ? pick_held_id() : lfia_pkg::ID_W'($urandom));
    endtask

    // Stop offering requests and wait for every outstanding reply.
    task automatic wait_until_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        // reset released on a falling edge; the block then clears its tree with tready low
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty pool, frees of unheld IDs, unused op, lowest-free reuse.
        issue(lfia_pkg::OP_CHECK, 10'd0);
        issue(lfia_pkg::OP_CHECK, 10'd1023);
        issue(lfia_pkg::OP_RELEASE, 10'd0);           // never allocated
        issue(lfia_pkg::OP_RELEASE, 10'd1023);
        issue(OP_UNUSED, 10'd1023);
        issue(OP_UNUSED, 10'd0);
        issue(lfia_pkg::OP_ALLOC, 10'd1023);          // id field is ignored on allocate
        issue(lfia_pkg::OP_ALLOC, 10'd0);
        issue(lfia_pkg::OP_ALLOC, 10'h2AA);
        issue(lfia_pkg::OP_ALLOC, 10'h155);
        issue(lfia_pkg::OP_CHECK, 10'd2);
        issue(lfia_pkg::OP_RELEASE, 10'd1);
        issue(lfia_pkg::OP_RELEASE, 10'd1);           // double free
        issue(lfia_pkg::OP_CHECK, 10'd1);
        issue(lfia_pkg::OP_ALLOC, 10'd0);             // the hole at 1 comes back first
        issue(lfia_pkg::OP_RELEASE, 10'd0);
        issue(lfia_pkg::OP_RELEASE, 10'd2);
        issue(lfia_pkg::OP_ALLOC, 10'd0);
        issue(lfia_pkg::OP_ALLOC, 10'd0);
        issue(lfia_pkg::OP_ALLOC, 10'd0);
        issue(lfia_pkg::OP_CHECK, 10'd4);
        issue(lfia_pkg::OP_CHECK, 10'd1023);

        // Phase: no idling, light occupancy.
        repeat (50) random_request(NUM_IDS / 8);
        // sender holds off until every reply is back
        wait_until_drained();

        // Phase: sender idles; fill the pool completely, then work at the brim.
        send_idle_pct = 66;
        while (granted_total < NUM_IDS)
            issue(lfia_pkg::OP_ALLOC, lfia_pkg::ID_W'($urandom));
        repeat (3) issue(lfia_pkg::OP_ALLOC, lfia_pkg::ID_W'($urandom));   // pool exhausted
        issue(lfia_pkg::OP_CHECK, 10'd1023);
        issue(lfia_pkg::OP_RELEASE, 10'd1023);        // top leaf frees and comes straight back
        issue(lfia_pkg::OP_ALLOC, 10'd0);
        issue(lfia_pkg::OP_RELEASE, 10'd512);
        issue(lfia_pkg::OP_RELEASE, 10'd0);
        issue(lfia_pkg::OP_ALLOC, 10'd0);
        issue(lfia_pkg::OP_ALLOC, 10'd0);
        issue(lfia_pkg::OP_ALLOC, 10'd0);
        repeat (30) random_request(NUM_IDS);

        // Phase: receiver stalls; drain towards half full.
        send_idle_pct  = 0;
        recv_stall_pct = 66;
        repeat (40) random_request(NUM_IDS / 2);

        // Phase: both sides idle now and then; drain towards empty.
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        repeat (40) random_request(0);

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d allocates (%0d on an exhausted pool), %0d releases, %0d checks,",
                 alloc_sent, full_hits, release_sent, check_sent);
        $display("%0d unused-op transactions; pool filled to %0d IDs, %0d still held at the end",
                 unused_sent, NUM_IDS, granted_total);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== lowest_free_id_allocator.f =====
hdl/lfia_pkg.sv
hdl/lfia_tree_mem.sv
hdl/lfia_seq.sv
hdl/lowest_free_id_allocator.sv
tb/lfia_result_checker.sv
tb/lowest_free_id_allocator_test.sv
